// ===== sv/fxalu_pkg.sv =====
// Shared constants, action codes and stage types for the Q24.8 ALU.
`timescale 1ns / 1ps
package fxalu_pkg;
  localparam int FracBits  = 8;
  localparam int DataW     = 32;
  localparam int MagW      = DataW + FracBits;   // widest shifted dividend magnitude
  localparam int QuotW     = MagW;
  localparam int DivCells  = QuotW;              // one quotient bit per cell
  localparam int CntW      = $clog2(DivCells + 4);

  typedef enum logic [3:0] {
    ACT_ADD  = 4'd0,  ACT_SUB  = 4'd1,  ACT_MUL  = 4'd2,  ACT_DIV  = 4'd3,
    ACT_LT   = 4'd4,  ACT_GT   = 4'd5,  ACT_EQ   = 4'd6,  ACT_NE   = 4'd7,
    ACT_MIN  = 4'd8,  ACT_MAX  = 4'd9,  ACT_INC  = 4'd10, ACT_DEC  = 4'd11,
    ACT_FINT = 4'd12, ACT_TINT = 4'd13
  } action_t;

  // Payload that travels down the row of cells.
  typedef struct packed {
    logic              valid;
    logic              is_div;
    logic              neg;       // quotient sign
    logic              dz;
    logic [DataW-1:0]  fast;      // result of non-divide actions
    logic              cmp;
    logic [MagW-1:0]   num;       // dividend magnitude, shifts left as bits are consumed
    logic [DataW-1:0]  den;       // divisor magnitude
    logic [DataW:0]    rem;       // partial remainder
    logic [QuotW-1:0]  quo;
  } cell_t;
endpackage

// ===== sv/fxalu_front.sv =====
// Front stage: evaluates every action but multiply and divide, forms the full product and prepares the divide.
`timescale 1ns / 1ps
module fxalu_front import fxalu_pkg::*; (
  input  logic              en,
  input  logic [3:0]        action,
  input  logic signed [31:0] operand_a,
  input  logic signed [31:0] operand_b,
  output logic signed [2*DataW-1:0] prod,
  output cell_t             head
);
  logic [DataW-1:0] mag_a, mag_b, rnd;
  logic             lt, gt;

  always_comb begin
    mag_a = operand_a[DataW-1] ? (~operand_a + 1'b1) : operand_a;
    mag_b = operand_b[DataW-1] ? (~operand_b + 1'b1) : operand_b;
    lt    = operand_a < operand_b;
    gt    = operand_a > operand_b;
    rnd   = DataW'(({1'b0, mag_a} + (33'd1 << (FracBits - 1))) >> FracBits);
    prod  = 64'(operand_a) * 64'(operand_b);
    head        = '0;
    head.valid  = en;
    case (action)
      ACT_ADD:  head.fast = operand_a + operand_b;
      ACT_SUB:  head.fast = operand_a - operand_b;
      ACT_DIV: begin
        head.is_div = 1'b1;
        head.dz     = (operand_b == '0);
        head.neg    = operand_a[DataW-1] ^ operand_b[DataW-1];
        head.num    = {mag_a, {FracBits{1'b0}}};
        head.den    = mag_b;
      end
      ACT_LT:   head.cmp = lt;
      ACT_GT:   head.cmp = gt;
      ACT_EQ:   head.cmp = (operand_a == operand_b);
      ACT_NE:   head.cmp = (operand_a != operand_b);
      ACT_MIN:  head.fast = lt ? operand_a : operand_b;
      ACT_MAX:  head.fast = gt ? operand_a : operand_b;
      ACT_INC:  head.fast = operand_a + 1'b1;
      ACT_DEC:  head.fast = operand_a - 1'b1;
      ACT_FINT: head.fast = operand_a << FracBits;
      ACT_TINT: head.fast = operand_a[DataW-1] ? (~rnd + 1'b1) : rnd;
      default:  head.fast = '0;
    endcase
  end
endmodule

// ===== sv/fxalu_cell.sv =====
// One restoring-divide cell: produces one quotient bit and passes the beat on.
`timescale 1ns / 1ps
module fxalu_cell import fxalu_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  advance,
  input  cell_t din,
  output cell_t dout
);
  logic [DataW:0] trial;
  logic [DataW:0] diff;
  cell_t          nxt;

  always_comb begin
    nxt   = din;
    trial = {din.rem[DataW-1:0], din.num[MagW-1]};
    diff  = trial - {1'b0, din.den};
    nxt.num = din.num << 1;
    if (!diff[DataW]) begin
      nxt.rem = diff;
      nxt.quo = {din.quo[QuotW-2:0], 1'b1};
    end else begin
      nxt.rem = trial;
      nxt.quo = {din.quo[QuotW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (advance) begin
      dout <= nxt;
    end
  end
endmodule

// ===== sv/fixed_point_q24_8_alu.sv =====
// Top level of the signed Q24.8 fixed-point ALU.
// Fully pipelined: one beat accepted per cycle unless the output stalls; every action
// passes the same stages (input register, one multiply register, a row of 40 divide cells,
// output register). The row length is set by the divide, which resolves one
// quotient bit per cell; all actions ride the same row so results stay in
// order. Stall on the output freezes the whole row.
`timescale 1ns / 1ps
module fixed_point_q24_8_alu import fxalu_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         action,
  input  logic signed [31:0] operand_a,
  input  logic signed [31:0] operand_b,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] result_value,
  output logic               compare_true,
  output logic               divide_by_zero
);
  cell_t front_cell, s0, s1, s1_next;
  logic signed [2*DataW-1:0] prod, prod_q;
  logic        mul_q;
  logic        advance;
  cell_t       row [DivCells+1];
  logic [QuotW-1:0] q_signed;

  // Row moves whenever the output register can take a beat.
  assign advance  = !out_valid || !out_stall;
  assign in_stall = !advance;

  fxalu_front u_front (
    .en(in_valid), .action(action), .operand_a(operand_a), .operand_b(operand_b),
    .prod(prod), .head(front_cell)
  );

  always_comb begin
    s1_next = s0;
    if (mul_q) s1_next.fast = DataW'(prod_q >>> FracBits);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0.valid <= 1'b0;
      s1.valid <= 1'b0;
    end else if (advance) begin
      s0     <= front_cell;
      mul_q  <= (action == ACT_MUL);
      prod_q <= prod;
      s1     <= s1_next;
    end
  end

  assign row[0] = s1;
  for (genvar i = 0; i < DivCells; i++) begin : g_cell
    fxalu_cell u_cell (.clk(clk), .rst(rst), .advance(advance), .din(row[i]), .dout(row[i+1]));
  end

  assign q_signed = row[DivCells].neg ? (~row[DivCells].quo + 1'b1) : row[DivCells].quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid      <= row[DivCells].valid;
      compare_true   <= row[DivCells].cmp;
      divide_by_zero <= row[DivCells].dz;
      if (row[DivCells].is_div)
        result_value <= row[DivCells].dz ? '0 : q_signed[DataW-1:0];
      else
        result_value <= row[DivCells].fast;
    end
  end
endmodule

// ===== sv/fxalu_checker.sv =====
// Port-level checker for the fixed-point ALU, bound to the top level.
`timescale 1ns / 1ps
module fxalu_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] result_value,
  input logic        compare_true,
  input logic        divide_by_zero
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(result_value)) else $error("beat dropped");
  a_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall) else $error("spurious input stall");
  a_dz: assert property (@(posedge clk) disable iff (rst)
    out_valid && divide_by_zero |-> result_value == 32'd0 && !compare_true)
    else $error("divide by zero result");
  a_rst: assert property (@(posedge clk) rst |=> !out_valid) else $error("valid after reset");
endmodule

bind fixed_point_q24_8_alu fxalu_checker u_chk (
  .clk(clk), .rst(rst), .in_stall(in_stall), .out_valid(out_valid), .out_stall(out_stall),
  .result_value(result_value), .compare_true(compare_true), .divide_by_zero(divide_by_zero)
);
